// ===== src/assert_macros.svh =====
// Assertion macros used by the resolver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge, suspended while rst_ni is low.
`define ASSERT_CLKED(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true on a rising clk_i edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/ptrr_pkg.sv =====
// Types and constants of the piece table range resolver.
package ptrr_pkg;

  // Table geometry
  localparam int MAX_PIECES = 64;
  localparam int IDX_W      = $clog2(MAX_PIECES);
  localparam int CNT_W      = $clog2(MAX_PIECES + 1);

  // Field widths
  localparam int POS_W  = 40;
  localparam int OFF_W  = 32;
  localparam int LEN_W  = 32;
  localparam int COFF_W = 33;

  // Request codes
  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_EXTRACT = 2'd2
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EMPTY = 3'b010,
    ST_WALK  = 3'b100
  } state_e;

  // Input word
  typedef struct packed {
    logic [1:0]       kind;
    logic             piece_source;
    logic [OFF_W-1:0] piece_offset;
    logic [LEN_W-1:0] piece_length;
    logic [POS_W-1:0] range_start;
    logic [POS_W-1:0] range_end;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic              chunk_valid;
    logic              chunk_source;
    logic [COFF_W-1:0] chunk_offset;
    logic [LEN_W-1:0]  chunk_length;
    logic              is_last;
    logic [POS_W-1:0]  total_length;
  } out_word_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic             source;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Result of evaluating one piece against the requested range
  typedef struct packed {
    logic              skip;
    logic              last;
    logic              source;
    logic [COFF_W-1:0] offset;
    logic [LEN_W-1:0]  length;
  } chunk_res_t;

endpackage

// ===== src/ptrr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ptrr_chunk_calc.sv =====
// Overlap of one piece with the requested range: chunk offset, length, flags.
module ptrr_chunk_calc import ptrr_pkg::*; (
  input  logic [POS_W-1:0] cursor_i,
  input  slot_t            slot_i,
  input  logic [POS_W-1:0] start_i,
  input  logic [POS_W-1:0] req_end_i,
  output chunk_res_t       res_o
);

  logic [POS_W-1:0] p_end;
  logic             head_cut;
  logic             tail_cut;
  logic [POS_W-1:0] delta;
  logic [POS_W-1:0] o_start;
  logic [POS_W-1:0] o_end;
  logic [POS_W-1:0] span;

  // Piece end position in the text
  assign p_end = cursor_i + {{(POS_W-LEN_W){1'b0}}, slot_i.length};

  // Range starts after the piece start / range ends before the piece end
  assign head_cut = cursor_i < start_i;
  assign tail_cut = req_end_i < p_end;

  assign delta   = start_i - cursor_i;
  assign o_start = head_cut ? start_i : cursor_i;
  assign o_end   = tail_cut ? req_end_i : p_end;
  assign span    = o_end - o_start;

  // Pack the result; delta is below the piece length when head_cut holds and the piece is not skipped
  always_comb begin
    res_o.skip   = p_end <= start_i;
    res_o.last   = !tail_cut ? (p_end == req_end_i) : 1'b1;
    res_o.source = slot_i.source;
    res_o.offset = {1'b0, slot_i.offset}
                 + (head_cut ? {1'b0, delta[OFF_W-1:0]} : {COFF_W{1'b0}});
    res_o.length = span[LEN_W-1:0];
  end

endmodule

// ===== src/piece_table_range_resolver.sv =====
// Piece table range resolver: request word in, chunk words out.
//
// Input channel (in_valid_i / in_stall_o / in_word_i) takes clear, append and
// extract requests. Clear and append give no output.
// An append to a full table is dropped. An extract is resolved by walking the
// table RAM one piece per cycle, while the output is free, from the first entry;
// each overlapping piece gives one chunk word on the output channel
// (out_valid_o / out_stall_i / out_word_o), the final one flagged is_last. An
// empty or beyond-text request gives a single word with chunk_valid low.
// An extract holds the input until its walk or its empty word is done; the
// walk visits the pieces up to and including the last overlapping one (at
// most 64), and the RAM read port delivers one entry per cycle while the
// output is free.
// The output register lets the walk run one word ahead of the receiver; while
// out_stall_i holds a word, the walk pauses on the current entry.
// Reset empties the table (count and total to zero); the RAM is not cleared,
// as only entries below the count are ever read.
`include "assert_macros.svh"

module piece_table_range_resolver import ptrr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] piece_count_q, piece_count_d;
  logic [POS_W-1:0] text_total_q, text_total_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [POS_W-1:0] cursor_q, cursor_d;
  logic [POS_W-1:0] start_q, start_d;
  logic [POS_W-1:0] req_end_q, req_end_d;
  out_word_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  slot_t            wr_slot;
  logic [SLOT_W-1:0] rd_data;
  slot_t            rd_slot;
  chunk_res_t       calc;
  logic             more;
  logic [POS_W-1:0] p_end;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Table RAM
  assign wr_slot.source = in_word_i.piece_source;
  assign wr_slot.offset = in_word_i.piece_offset;
  assign wr_slot.length = in_word_i.piece_length;
  assign ram_we = in_acc && (in_word_i.kind == KIND_APPEND)
               && (piece_count_q < CNT_W'(MAX_PIECES));

  ptrr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_PIECES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (piece_count_q[IDX_W-1:0]),
    .wdata_i (wr_slot),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  assign rd_slot = slot_t'(rd_data);

  // Chunk for the entry now on the RAM output
  ptrr_chunk_calc u_calc (
    .cursor_i  (cursor_q),
    .slot_i    (rd_slot),
    .start_i   (start_q),
    .req_end_i (req_end_q),
    .res_o     (calc)
  );

  assign p_end = cursor_q + {{(POS_W-LEN_W){1'b0}}, rd_slot.length};
  assign more  = ({1'b0, idx_q} + CNT_W'(1)) < piece_count_q;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    piece_count_d = piece_count_q;
    text_total_d  = text_total_q;
    idx_d         = idx_q;
    cursor_d      = cursor_q;
    start_d       = start_q;
    req_end_d     = req_end_q;
    out_d         = out_q;
    out_load      = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = idx_q + IDX_W'(1);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_word_i.kind)
            KIND_CLEAR: begin
              piece_count_d = '0;
              text_total_d  = '0;
            end
            KIND_APPEND: begin
              if (piece_count_q < CNT_W'(MAX_PIECES)) begin
                piece_count_d = piece_count_q + CNT_W'(1);
                text_total_d  = text_total_q
                              + {{(POS_W-LEN_W){1'b0}}, in_word_i.piece_length};
              end
            end
            KIND_EXTRACT: begin
              start_d   = in_word_i.range_start;
              req_end_d = (in_word_i.range_end < text_total_q) ?
                          in_word_i.range_end : text_total_q;
              if ((in_word_i.range_start >= in_word_i.range_end) ||
                  (in_word_i.range_start >= text_total_q)) begin
                state_d = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                cursor_d  = '0;
                state_d   = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_d.chunk_valid  = 1'b0;
          out_d.chunk_source = 1'b0;
          out_d.chunk_offset = '0;
          out_d.chunk_length = '0;
          out_d.is_last      = 1'b1;
          out_d.total_length = text_total_q;
          state_d            = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (!calc.skip) begin
            out_load           = 1'b1;
            out_d.chunk_valid  = 1'b1;
            out_d.chunk_source = calc.source;
            out_d.chunk_offset = calc.offset;
            out_d.chunk_length = calc.length;
            out_d.is_last      = calc.last || !more;
            out_d.total_length = text_total_q;
          end
          if ((!calc.skip && calc.last) || !more) begin
            state_d = ST_IDLE;
          end else begin
            ram_re   = 1'b1;
            idx_d    = idx_q + IDX_W'(1);
            cursor_d = p_end;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      piece_count_q <= '0;
      text_total_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      piece_count_q <= piece_count_d;
      text_total_q  <= text_total_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Walk and payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cursor_q  <= cursor_d;
    start_q   <= start_d;
    req_end_q <= req_end_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  `ASSERT_CLKED(a_count_bound, (piece_count_q <= CNT_W'(MAX_PIECES)), "piece count overflow")
  `ASSERT_CLKED(a_walk_idx, (state_q == ST_WALK) |-> ({1'b0, idx_q} < piece_count_q), "walk past table")
  `ASSERT_CLKED(a_last_ends, (out_load && out_d.is_last) |=> (state_q == ST_IDLE), "walk runs past last chunk")
  `ASSERT_NEVER(a_no_overwrite, out_load && out_valid_q && out_stall_i, "held word overwritten")

endmodule
